FILE: rtl/tilt_alarm_controller_defines.svh
// Assertion macros shared by the tilt alarm controller RTL.
// Each macro samples on clk; TAC_ASSERT is disabled while the active-low reset arst_n of the including module is low.
`ifndef TILT_ALARM_CONTROLLER_DEFINES_SVH
`define TILT_ALARM_CONTROLLER_DEFINES_SVH
`ifndef SYNTHESIS
`define TAC_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define TAC_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define TAC_ASSERT(lbl, prop, msg)
`define TAC_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

FILE: rtl/tac_pkg.sv
// Types and constants for the tilt alarm controller.
// No dependencies; used by tac_cfg_regs, tac_core and tilt_alarm_controller.
package tac_pkg;

	localparam logic OP_TICK = 1'b0;
	localparam logic OP_CODE = 1'b1;

	localparam logic [1:0] CODE_PASSWORD  = 2'd0;
	localparam logic [1:0] CODE_RECONNECT = 2'd1;
	localparam logic [1:0] CODE_TEST      = 2'd2;

	localparam logic [2:0] CFG_TILT_LIMIT      = 3'd0;
	localparam logic [2:0] CFG_SIREN_TICKS     = 3'd1;
	localparam logic [2:0] CFG_SHOCK_WINDOW    = 3'd2;
	localparam logic [2:0] CFG_SHOCK_HOLDOFF   = 3'd3;
	localparam logic [2:0] CFG_SPEAKER_LEVEL   = 3'd4;
	localparam logic [2:0] CFG_ARMED_BLINK_GAP = 3'd5;
	localparam logic [2:0] CFG_DISARMED_BLINK  = 3'd6;

	localparam logic [7:0]  RST_TILT_LIMIT      = 8'd10;
	localparam logic [15:0] RST_SIREN_TICKS     = 16'd600;
	localparam logic [15:0] RST_SHOCK_WINDOW    = 16'd100;
	localparam logic [7:0]  RST_SHOCK_HOLDOFF   = 8'd10;
	localparam logic [7:0]  RST_SPEAKER_LEVEL   = 8'd140;
	localparam logic [9:0]  RST_ARMED_BLINK_GAP = 10'd100;
	localparam logic [7:0]  RST_DISARMED_BLINK  = 8'd5;

	localparam logic [7:0] EDGE_MAX  = 8'd255;
	localparam logic [7:0] SINCE_MAX = 8'd255;

	typedef struct packed {
		logic       opcode;
		logic       tilt_level;
		logic       tamper_level;
		logic [1:0] code_class;
		logic       link_up;
	} tac_item_t;

	typedef struct packed {
		logic [7:0]  tilt_limit;
		logic [15:0] siren_ticks;
		logic [15:0] shock_window_ticks;
		logic [7:0]  shock_holdoff_ticks;
		logic [7:0]  speaker_level;
		logic [9:0]  armed_blink_gap_ticks;
		logic [7:0]  disarmed_blink_ticks;
	} tac_cfg_t;

	typedef struct packed {
		logic       test_request;
		logic       reconnect_request;
		logic       tampered;
		logic       siren_active;
		logic       alarm_status;
		logic       armed_status;
		logic [7:0] speaker_drive;
		logic       lamp_right;
		logic       lamp_left;
	} tac_result_t;

endpackage

FILE: rtl/tac_cfg_regs.sv
// Configuration register file of the tilt alarm controller.
// Depends on tac_pkg for register indexes, reset values and the tac_cfg_t bundle.
module tac_cfg_regs (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [2:0]        cfg_index,
	input  logic [15:0]       cfg_data,
	output tac_pkg::tac_cfg_t cfg
);
	import tac_pkg::*;

	tac_cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.tilt_limit            <= RST_TILT_LIMIT;
			cfg_q.siren_ticks           <= RST_SIREN_TICKS;
			cfg_q.shock_window_ticks    <= RST_SHOCK_WINDOW;
			cfg_q.shock_holdoff_ticks   <= RST_SHOCK_HOLDOFF;
			cfg_q.speaker_level         <= RST_SPEAKER_LEVEL;
			cfg_q.armed_blink_gap_ticks <= RST_ARMED_BLINK_GAP;
			cfg_q.disarmed_blink_ticks  <= RST_DISARMED_BLINK;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_TILT_LIMIT:      cfg_q.tilt_limit            <= cfg_data[7:0];
				CFG_SIREN_TICKS:     cfg_q.siren_ticks           <= cfg_data;
				CFG_SHOCK_WINDOW:    cfg_q.shock_window_ticks    <= cfg_data;
				CFG_SHOCK_HOLDOFF:   cfg_q.shock_holdoff_ticks   <= cfg_data[7:0];
				CFG_SPEAKER_LEVEL:   cfg_q.speaker_level         <= cfg_data[7:0];
				CFG_ARMED_BLINK_GAP: cfg_q.armed_blink_gap_ticks <= cfg_data[9:0];
				CFG_DISARMED_BLINK:  cfg_q.disarmed_blink_ticks  <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

endmodule

FILE: rtl/tac_core.sv
// Alarm state and its single-pass update for one tick or code entry.
// Depends on tac_pkg and the assertion macros in tilt_alarm_controller_defines.svh.
`include "tilt_alarm_controller_defines.svh"
module tac_core (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 fire,
	input  tac_pkg::tac_item_t   item,
	input  tac_pkg::tac_cfg_t    cfg,
	output tac_pkg::tac_result_t res
);
	import tac_pkg::*;

	logic        armed_q, alarm_q, ref_q, spk_en_q, spk_ph_q, led_ph_q;
	logic        tamper_q, left_q, right_q;
	logic [7:0]  edges_q, since_q;
	logic [15:0] siren_q, shock_q;
	logic [9:0]  cd_q;

	logic        armed_n, alarm_n, ref_n, spk_en_n, spk_ph_n, led_ph_n;
	logic        tamper_n, left_n, right_n;
	logic [7:0]  edges_n, since_n;
	logic [15:0] siren_n, shock_n;
	logic [9:0]  cd_n;
	logic        reconnect, test;
	logic [9:0]  dis_reload, gap_reload;

	assign dis_reload = (cfg.disarmed_blink_ticks == 8'd0) ? 10'd1
		: {2'b00, cfg.disarmed_blink_ticks};
	assign gap_reload = (cfg.armed_blink_gap_ticks == 10'd0) ? 10'd1
		: cfg.armed_blink_gap_ticks;

	always_comb begin
		armed_n   = armed_q;
		alarm_n   = alarm_q;
		ref_n     = ref_q;
		spk_en_n  = spk_en_q;
		spk_ph_n  = spk_ph_q;
		led_ph_n  = led_ph_q;
		tamper_n  = tamper_q;
		left_n    = left_q;
		right_n   = right_q;
		edges_n   = edges_q;
		since_n   = since_q;
		siren_n   = siren_q;
		shock_n   = shock_q;
		cd_n      = cd_q;
		reconnect = 1'b0;
		test      = 1'b0;
		if (item.opcode == OP_TICK) begin
			// Timers advance before anything looks at them.
			if (siren_q != 16'd0) siren_n = siren_q - 16'd1;
			if (shock_q != 16'd0) begin
				shock_n = shock_q - 16'd1;
			end else if (since_q != SINCE_MAX) begin
				since_n = since_q + 8'd1;
			end
			if (armed_q && !alarm_q && (item.tilt_level != ref_q)) begin
				if (edges_q != EDGE_MAX) edges_n = edges_q + 8'd1;
				ref_n = item.tilt_level;
				if (edges_n > cfg.tilt_limit) begin
					alarm_n  = 1'b1;
					spk_en_n = 1'b1;
					siren_n  = cfg.siren_ticks;
					cd_n     = 10'd1;
				end
			end else if (!armed_q && (item.tilt_level != ref_q) && (shock_n == 16'd0)
					&& (since_n >= cfg.shock_holdoff_ticks)) begin
				ref_n   = item.tilt_level;
				shock_n = cfg.shock_window_ticks;
				since_n = 8'd0;
			end
			if (item.tamper_level) tamper_n = 1'b1;
			if (spk_en_n) spk_ph_n = !spk_ph_q;
			if (cd_n <= 10'd1) begin
				if (armed_q) begin
					if (alarm_n) begin
						left_n   = led_ph_q;
						right_n  = led_ph_q;
						led_ph_n = !led_ph_q;
						cd_n     = 10'd1;
					end else begin
						left_n = 1'b0;
						if (led_ph_q) begin
							right_n  = 1'b1;
							led_ph_n = 1'b0;
							cd_n     = 10'd1;
						end else begin
							right_n  = 1'b0;
							led_ph_n = 1'b1;
							cd_n     = gap_reload;
						end
					end
				end else begin
					if (shock_n != 16'd0) begin
						left_n   = led_ph_q;
						right_n  = !led_ph_q;
						led_ph_n = !led_ph_q;
					end else begin
						left_n  = 1'b0;
						right_n = 1'b0;
					end
					cd_n = dis_reload;
				end
				if (!item.link_up) left_n = 1'b1;
			end else begin
				cd_n = cd_n - 10'd1;
			end
		end else begin
			case (item.code_class)
				CODE_PASSWORD: begin
					armed_n  = !armed_q;
					alarm_n  = 1'b0;
					spk_en_n = 1'b0;
					if (armed_q) begin
						right_n = 1'b1;
						cd_n    = dis_reload;
					end else begin
						left_n  = 1'b1;
						right_n = 1'b1;
						edges_n = 8'd0;
					end
				end
				CODE_RECONNECT: begin
					if (!armed_q) begin
						reconnect = 1'b1;
						right_n   = 1'b1;
					end
				end
				CODE_TEST: begin
					if (!armed_q) test = 1'b1;
				end
				default: ;
			endcase
		end
	end

	always_comb begin
		res.lamp_left         = left_n;
		res.lamp_right        = right_n;
		res.speaker_drive     = (spk_en_n && (siren_n != 16'd0) && !spk_ph_n)
			? cfg.speaker_level : 8'd0;
		res.armed_status      = armed_n;
		res.alarm_status      = alarm_n;
		res.siren_active      = (siren_n != 16'd0);
		res.tampered          = tamper_n;
		res.reconnect_request = reconnect;
		res.test_request      = test;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			armed_q  <= 1'b1;
			alarm_q  <= 1'b0;
			ref_q    <= 1'b0;
			spk_en_q <= 1'b0;
			spk_ph_q <= 1'b0;
			led_ph_q <= 1'b0;
			tamper_q <= 1'b0;
			left_q   <= 1'b0;
			right_q  <= 1'b0;
			edges_q  <= 8'd0;
			since_q  <= SINCE_MAX;
			siren_q  <= 16'd0;
			shock_q  <= 16'd0;
			cd_q     <= {2'b00, RST_DISARMED_BLINK};
		end else if (fire) begin
			armed_q  <= armed_n;
			alarm_q  <= alarm_n;
			ref_q    <= ref_n;
			spk_en_q <= spk_en_n;
			spk_ph_q <= spk_ph_n;
			led_ph_q <= led_ph_n;
			tamper_q <= tamper_n;
			left_q   <= left_n;
			right_q  <= right_n;
			edges_q  <= edges_n;
			since_q  <= since_n;
			siren_q  <= siren_n;
			shock_q  <= shock_n;
			cd_q     <= cd_n;
		end
	end

	// The alarm can only trip while armed, and a password entry clears the alarm and toggles the armed state.
	`TAC_ASSERT(a_alarm_needs_armed, alarm_q |-> armed_q, "alarm set while disarmed")
	// The speaker is only enabled by a trip and silenced with the alarm.
	`TAC_ASSERT(a_speaker_needs_alarm, spk_en_q |-> alarm_q, "speaker enabled without alarm")
	// Every reload of the LED countdown is at least one tick; reset loads a nonzero value.
	`TAC_ASSERT_ALWAYS(a_led_countdown_nonzero, !arst_n || (cd_q != 10'd0), "LED countdown reached zero")
	// Request pulses come from different codes and never share one result.
	`TAC_ASSERT(a_requests_exclusive, !(reconnect && test), "both request pulses set")

endmodule

FILE: rtl/tilt_alarm_controller.sv
// Top level of the tilt alarm controller: input register, state core, result register.
// Depends on tac_pkg, tac_cfg_regs and tac_core.
//
//  channel | direction | handshake          | payload
//  s_*     | in        | s_tvalid/s_tready  | s_tuser = opcode, s_tdata = sensor levels, code
//  m_*     | out       | m_tvalid/m_tready  | m_tdata = LEDs, speaker, status, request pulses
//  cfg_*   | in        | cfg_valid/cfg_ready| cfg_index selects register, cfg_data is value
//
// Each request is held in the input register and is then evaluated in a single pass
// against the alarm state, producing its result into the output register, so one
// request is taken every cycle when m_tready stays high. The throughput rests on the
// state update in tac_core being done in a single pass per request.
// Reset is asynchronous and active low; it restores the armed state and the register
// defaults. A stalled result holds the output register, and the input register still
// takes one further request; after that s_tready drops until the result is taken.
module tilt_alarm_controller (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [0] tilt_level, [1] tamper_level, [3:2] code_class,
	                               // [4] link_up, [7:5] zero
	input  logic        s_tuser,   // [0] opcode: 0 tick, 1 code entry
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // [0] lamp_left, [1] lamp_right, [9:2] speaker_drive,
	                               // [10] armed_status, [11] alarm_status, [12] siren_active,
	                               // [13] tampered, [14] reconnect_request, [15] test_request
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data
);
	import tac_pkg::*;

	tac_cfg_t    cfg;
	tac_item_t   item_s1;
	logic        valid_s1;
	tac_result_t res;
	logic        advance;
	logic        out_valid_q;
	tac_result_t out_q;

	// The item moves into the result register whenever that register is free or drains.
	assign advance  = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;

	tac_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	tac_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (advance),
		.item   (item_s1),
		.cfg    (cfg),
		.res    (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	// Payload registers carry no reset.
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			item_s1.opcode       <= s_tuser;
			item_s1.tilt_level   <= s_tdata[0];
			item_s1.tamper_level <= s_tdata[1];
			item_s1.code_class   <= s_tdata[3:2];
			item_s1.link_up      <= s_tdata[4];
		end
		if (advance) begin
			out_q <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_q;

endmodule
